>>> rtl/dual_acia_serial_registers_assert.svh
// Assertion macros for the checker file of the dual serial register block.
// Both macros need a signal named clk in the scope where they are used; DACIA_ASSERT also needs rst_n.
`ifndef DUAL_ACIA_SERIAL_REGISTERS_ASSERT_SVH
`define DUAL_ACIA_SERIAL_REGISTERS_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define DACIA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also runs during reset.
`define DACIA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/dacia_pkg.sv
// ----------------------------------------------------------------------------
// dacia_pkg
// Types, field widths and register bit positions for the dual serial
// register block.
// ----------------------------------------------------------------------------
`default_nettype none

package dacia_pkg;

  // Field widths.
  localparam int CMD_W  = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 8;

  // Default number of chips.
  localparam int CHANNELS_DEF = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_BUS_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUS_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LINE_RX   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LINE_TAKE = 2'd3;

  // Bus offset decode.
  localparam int ADDR_ODD_BIT  = 0;
  localparam int ADDR_REG_BIT  = 1;
  localparam int ADDR_CHIP_BIT = 2;
  localparam logic REG_CTRL = 1'b0;
  localparam logic REG_DATA = 1'b1;

  // Control register.
  localparam logic [1:0] CT_MASTER_RESET = 2'b11;
  localparam int         CT_RIE_BIT      = 7;

  // Status register bit positions.
  localparam int ST_RDRF_BIT = 0;
  localparam int ST_TDRE_BIT = 1;
  localparam int ST_OVRN_BIT = 5;
  localparam int ST_IRQ_BIT  = 7;

  // One input word.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;
    logic              channel;
    logic [DATA_W-1:0] data;
  } dacia_req_t;

  // One result word.
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              tx_valid;
    logic [DATA_W-1:0] tx_byte;
    logic              irq_any;
  } dacia_rsp_t;

  // Status byte as the bus sees it; transmitter-empty is always set.
  function automatic logic [DATA_W-1:0] status_byte(input logic rie, input logic rdrf,
                                                    input logic ovrn);
    logic [DATA_W-1:0] s;
    s = '0;
    s[ST_RDRF_BIT] = rdrf;
    s[ST_TDRE_BIT] = 1'b1;
    s[ST_OVRN_BIT] = ovrn;
    s[ST_IRQ_BIT]  = rie & (rdrf | ovrn);
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dacia_if.sv
// ----------------------------------------------------------------------------
// dacia_if
// Valid/ready channels for the command words and the result words of the
// dual serial register block.
// ----------------------------------------------------------------------------
`default_nettype none

interface dacia_in_if;
  import dacia_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] address;
  logic              channel;
  logic [DATA_W-1:0] data;

  modport source (output valid, output cmd, output address, output channel, output data,
                  input ready);
  modport sink   (input valid, input cmd, input address, input channel, input data,
                  output ready);
endinterface

interface dacia_out_if;
  import dacia_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              tx_valid;
  logic [DATA_W-1:0] tx_byte;
  logic              irq_any;

  modport source (output valid, output read_data, output tx_valid, output tx_byte,
                  output irq_any, input ready);
  modport sink   (input valid, input read_data, input tx_valid, input tx_byte,
                  input irq_any, output ready);
endinterface

`default_nettype wire

>>> rtl/dual_acia_serial_registers.sv
// Usage:
// Two simplified serial interface chips behind a byte bus. Each word on in_ch
// carries one command: a bus read, a bus write, a byte arriving from the line
// or a request to take the byte waiting to be sent. Every accepted word gives
// exactly one word on out_ch with the read value, the handed-over transmit
// byte and the combined interrupt flag after the command.
// A word is taken into an input register, decoded against the per-chip flags
// in one pass of logic and written to an output register, from which out_ch
// is driven. One word is accepted per cycle while out_ch is not stalled; the
// chip registers are updated as the word leaves the input register, so a word
// always sees the effects of the one before it.
// Reset clears control, flags, the receive byte and the transmit-pending
// bits of both chips; in_ch.ready is high when reset ends.
// When the receiver stalls, the output register holds its word, the input
// register takes one more word, and then in_ch.ready drops until out_ch moves.
// ----------------------------------------------------------------------------
// dual_acia_serial_registers
// Register model of two serial interface chips with a bus side and a line side.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_acia_serial_registers #(
  parameter int CHANNELS = dacia_pkg::CHANNELS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  dacia_in_if.sink     in_ch,
  dacia_out_if.source  out_ch
);
  import dacia_pkg::*;

  // Pipeline control.
  logic       in_valid_r;
  logic       out_valid_r;
  logic       advance;
  dacia_req_t req_r;
  dacia_rsp_t rsp_r;
  dacia_rsp_t rsp_nxt;

  // Per-chip state.
  logic              rie_r   [CHANNELS];
  logic              rdrf_r  [CHANNELS];
  logic              ovrn_r  [CHANNELS];
  logic [DATA_W-1:0] rx_r    [CHANNELS];
  logic [DATA_W-1:0] txh_r   [CHANNELS];
  logic              txp_r   [CHANNELS];
  logic              rie_nxt [CHANNELS];
  logic              rdrf_nxt[CHANNELS];
  logic              ovrn_nxt[CHANNELS];
  logic [DATA_W-1:0] rx_nxt  [CHANNELS];
  logic [DATA_W-1:0] txh_nxt [CHANNELS];
  logic              txp_nxt [CHANNELS];

  // The word moves on when the output register is free or being emptied.
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_r <= '{cmd: in_ch.cmd, address: in_ch.address, channel: in_ch.channel,
                 data: in_ch.data};
    end
  end

  // Decode the word against the chip state and work out the next state.
  always_comb begin
    rsp_nxt = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      rie_nxt[c]  = rie_r[c];
      rdrf_nxt[c] = rdrf_r[c];
      ovrn_nxt[c] = ovrn_r[c];
      rx_nxt[c]   = rx_r[c];
      txh_nxt[c]  = txh_r[c];
      txp_nxt[c]  = txp_r[c];
    end

    for (int c = 0; c < CHANNELS; c++) begin
      case (req_r.cmd)
        CMD_BUS_READ: begin
          if (!req_r.address[ADDR_ODD_BIT] && int'(req_r.address[ADDR_CHIP_BIT]) == c) begin
            if (req_r.address[ADDR_REG_BIT] == REG_DATA) begin
              rsp_nxt.read_data = rx_r[c];
              rdrf_nxt[c]       = 1'b0;
              ovrn_nxt[c]       = 1'b0;
            end else begin
              rsp_nxt.read_data = status_byte(rie_r[c], rdrf_r[c], ovrn_r[c]);
            end
          end
        end
        CMD_BUS_WRITE: begin
          if (!req_r.address[ADDR_ODD_BIT] && int'(req_r.address[ADDR_CHIP_BIT]) == c) begin
            if (req_r.address[ADDR_REG_BIT] == REG_CTRL) begin
              // Master reset clears the flags, the receive byte and the pending bit, not the hold byte.
              if (req_r.data[1:0] == CT_MASTER_RESET) begin
                rdrf_nxt[c] = 1'b0;
                ovrn_nxt[c] = 1'b0;
                rx_nxt[c]   = '0;
                txp_nxt[c]  = 1'b0;
              end
              rie_nxt[c] = req_r.data[CT_RIE_BIT];
            end else begin
              txh_nxt[c] = req_r.data;
              txp_nxt[c] = 1'b1;
            end
          end
        end
        CMD_LINE_RX: begin
          if (int'(req_r.channel) == c) begin
            // A byte arriving on a full receiver flags an overrun and replaces it.
            if (rdrf_r[c]) begin
              ovrn_nxt[c] = 1'b1;
            end
            rx_nxt[c]   = req_r.data;
            rdrf_nxt[c] = 1'b1;
          end
        end
        CMD_LINE_TAKE: begin
          if (int'(req_r.channel) == c && txp_r[c]) begin
            rsp_nxt.tx_valid = 1'b1;
            rsp_nxt.tx_byte  = txh_r[c];
            txp_nxt[c]       = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    // Interrupt summary after the update.
    for (int c = 0; c < CHANNELS; c++) begin
      if (rie_nxt[c] && (rdrf_nxt[c] || ovrn_nxt[c])) begin
        rsp_nxt.irq_any = 1'b1;
      end
    end
  end

  // Chip state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rie_r[c]  <= 1'b0;
        rdrf_r[c] <= 1'b0;
        ovrn_r[c] <= 1'b0;
        rx_r[c]   <= '0;
        txp_r[c]  <= 1'b0;
      end
    end else if (advance) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rie_r[c]  <= rie_nxt[c];
        rdrf_r[c] <= rdrf_nxt[c];
        ovrn_r[c] <= ovrn_nxt[c];
        rx_r[c]   <= rx_nxt[c];
        txp_r[c]  <= txp_nxt[c];
      end
    end
  end

  // The hold byte is only seen while its pending bit is set.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int c = 0; c < CHANNELS; c++) begin
        txh_r[c] <= txh_nxt[c];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = rsp_r.read_data;
  assign out_ch.tx_valid  = rsp_r.tx_valid;
  assign out_ch.tx_byte   = rsp_r.tx_byte;
  assign out_ch.irq_any   = rsp_r.irq_any;

endmodule

`default_nettype wire

>>> rtl/dacia_checker.sv
// ----------------------------------------------------------------------------
// dacia_checker
// Port-level checks for the dual serial register block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_acia_serial_registers_assert.svh"

module dacia_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire [dacia_pkg::DATA_W-1:0] read_data,
  input wire                        tx_valid,
  input wire [dacia_pkg::DATA_W-1:0] tx_byte,
  input wire                        irq_any
);

  // A stalled result word keeps its contents.
  `DACIA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(tx_valid) && $stable(tx_byte) && $stable(irq_any), "stalled result word changed")

  // No transmit byte is shown unless one was handed over.
  `DACIA_ASSERT(a_tx_byte_zero, out_valid && !tx_valid |-> tx_byte == 8'd0, "transmit byte without transmit valid")

  // A take word never carries bus read data.
  `DACIA_ASSERT(a_take_no_read, out_valid && tx_valid |-> read_data == 8'd0, "read data on a take word")

  // A fresh result follows a word that was accepted and passed through the input register.
  `DACIA_ASSERT(a_out_latency, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result word without an accepted command")

  // Reset empties the output and opens the input.
  `DACIA_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && in_ready, "block not idle after reset")

endmodule

bind dual_acia_serial_registers dacia_checker u_dacia_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .read_data (out_ch.read_data),
  .tx_valid  (out_ch.tx_valid),
  .tx_byte   (out_ch.tx_byte),
  .irq_any   (out_ch.irq_any)
);

`default_nettype wire

>>> verif/dual_acia_serial_registers_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_acia_serial_registers_tb
// Self-checking bench for the dual serial register block. Command words are
// sent on in_ch with random gaps, and result words are taken from out_ch under
// random and long stalls. A scoreboard class tracks the flags and bytes of
// both chips, predicts one reply per accepted command and compares each reply
// field by field in order.
// ----------------------------------------------------------------------------

module dual_acia_serial_registers_tb;
  import dacia_pkg::*;

  // Tracks both chips and holds the replies that are still to come.
  class acia_pair_scoreboard;
    logic [DATA_W-1:0] ctrl [2];
    logic              rx_full [2];
    logic              overrun [2];
    logic [DATA_W-1:0] rx_hold [2];
    logic [DATA_W-1:0] tx_hold [2];
    logic              tx_waiting [2];
    dacia_rsp_t        due_replies [$];
    int                errors;

    function new();
      for (int c = 0; c < 2; c++) begin
        ctrl[c]       = '0;
        rx_full[c]    = 1'b0;
        overrun[c]    = 1'b0;
        rx_hold[c]    = '0;
        tx_hold[c]    = '0;
        tx_waiting[c] = 1'b0;
      end
      errors = 0;
    endfunction

    // Interrupt flag of one chip: receive interrupts enabled and a byte or
    // an overrun is waiting.
    function logic chip_irq(int c);
      return ctrl[c][CT_RIE_BIT] & (rx_full[c] | overrun[c]);
    endfunction

    // Status byte as a bus read returns it.
    function logic [DATA_W-1:0] chip_status(int c);
      logic [DATA_W-1:0] s;
      s = '0;
      s[ST_RDRF_BIT] = rx_full[c];
      s[ST_TDRE_BIT] = 1'b1;
      s[ST_OVRN_BIT] = overrun[c];
      s[ST_IRQ_BIT]  = chip_irq(c);
      return s;
    endfunction

    // Applies one accepted command and queues the reply it causes.
    function void note_command(dacia_req_t w);
      dacia_rsp_t r;
      int         chip;
      logic       even;
      r    = '0;
      chip = int'(w.address[ADDR_CHIP_BIT]);
      even = !w.address[ADDR_ODD_BIT];
      case (w.cmd)
        CMD_BUS_READ: begin
          if (even) begin
            if (w.address[ADDR_REG_BIT] == REG_CTRL) begin
              r.read_data = chip_status(chip);
            end else begin
              rx_full[chip] = 1'b0;
              overrun[chip] = 1'b0;
              r.read_data   = rx_hold[chip];
            end
          end
        end
        CMD_BUS_WRITE: begin
          if (even) begin
            if (w.address[ADDR_REG_BIT] == REG_CTRL) begin
              // A master reset drops the flags, the received byte and any
              // pending transmit byte; the hold register itself survives.
              if (w.data[1:0] == CT_MASTER_RESET) begin
                rx_full[chip]    = 1'b0;
                overrun[chip]    = 1'b0;
                rx_hold[chip]    = '0;
                tx_waiting[chip] = 1'b0;
              end
              ctrl[chip] = w.data;
            end else begin
              tx_hold[chip]    = w.data;
              tx_waiting[chip] = 1'b1;
            end
          end
        end
        CMD_LINE_RX: begin
          if (rx_full[w.channel]) overrun[w.channel] = 1'b1;
          rx_hold[w.channel] = w.data;
          rx_full[w.channel] = 1'b1;
        end
        default: begin
          if (tx_waiting[w.channel]) begin
            r.tx_valid            = 1'b1;
            r.tx_byte             = tx_hold[w.channel];
            tx_waiting[w.channel] = 1'b0;
          end
        end
      endcase
      r.irq_any = chip_irq(0) | chip_irq(1);
      due_replies.push_back(r);
    endfunction

    function void field_check(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compares one reply with the oldest prediction.
    function void check_reply(dacia_rsp_t got);
      dacia_rsp_t want;
      if (due_replies.size() == 0) begin
        $display("%0t: reply word with nothing expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = due_replies.pop_front();
      field_check("read_data", want.read_data, got.read_data);
      field_check("tx_valid", {7'd0, want.tx_valid}, {7'd0, got.tx_valid});
      field_check("tx_byte", want.tx_byte, got.tx_byte);
      field_check("irq_any", {7'd0, want.irq_any}, {7'd0, got.irq_any});
    endfunction
  endclass

  logic clk;
  logic rst_n;

  dacia_in_if  in_ch ();
  dacia_out_if out_ch ();

  dual_acia_serial_registers u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  acia_pair_scoreboard sb = new();

  // Shared between the stimulus and the receiver.
  bit steady;
  bit hold_off_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // Sender gap: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  // Offers one command word and waits until the block takes it.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr, logic chan,
                              logic [DATA_W-1:0] data);
    dacia_req_t w;
    int         gap;
    w.cmd     = cmd;
    w.address = addr;
    w.channel = chan;
    w.data    = data;
    gap       = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= w.cmd;
    in_ch.address <= w.address;
    in_ch.channel <= w.channel;
    in_ch.data    <= w.data;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(w);
  endtask

  // Random command; odd offsets are kept rare so most bus accesses land.
  task automatic send_random();
    logic [ADDR_W-1:0] addr;
    addr = {2'($urandom_range(0, 3)), 1'b0};
    if ($urandom_range(0, 7) == 0) addr[ADDR_ODD_BIT] = 1'b1;
    send_command(2'($urandom_range(0, 3)), addr, 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 255)));
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall_left;
    int r;
    stall_left   = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        stall_left   = 64;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          out_ch.ready <= 1'b1;
        end else if (r < 95) begin
          out_ch.ready <= 1'b0;
          stall_left   = $urandom_range(0, 2);
        end else begin
          out_ch.ready <= 1'b0;
          stall_left   = $urandom_range(10, 30);
        end
      end
    end
  end

  // Reply monitor.
  always @(posedge clk) begin
    dacia_rsp_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.read_data = out_ch.read_data;
      got.tx_valid  = out_ch.tx_valid;
      got.tx_byte   = out_ch.tx_byte;
      got.irq_any   = out_ch.irq_any;
      sb.check_reply(got);
    end
  end

  // Stimulus and end of run.
  initial begin
    int drain;
    steady        = 1'b0;
    hold_off_req  = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.cmd     <= CMD_BUS_READ;
    in_ch.address <= '0;
    in_ch.channel <= 1'b0;
    in_ch.data    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset values, ignored offsets, overrun, repeated data reads,
    // replaced transmit bytes, empty takes and master resets.
    send_command(CMD_BUS_READ, 3'd0, 1'b0, 8'h00);
    send_command(CMD_BUS_READ, 3'd4, 1'b0, 8'h00);
    send_command(CMD_BUS_READ, 3'd2, 1'b0, 8'h00);
    send_command(CMD_BUS_READ, 3'd1, 1'b0, 8'h00);
    send_command(CMD_BUS_WRITE, 3'd7, 1'b1, 8'hFF);
    send_command(CMD_BUS_WRITE, 3'd0, 1'b0, 8'h80);
    send_command(CMD_LINE_RX, 3'd0, 1'b0, 8'hA5);
    send_command(CMD_BUS_READ, 3'd0, 1'b0, 8'h00);
    send_command(CMD_LINE_RX, 3'd7, 1'b0, 8'hFF);
    send_command(CMD_BUS_READ, 3'd0, 1'b0, 8'h00);
    send_command(CMD_BUS_READ, 3'd2, 1'b0, 8'h00);
    send_command(CMD_BUS_READ, 3'd2, 1'b0, 8'h00);
    send_command(CMD_BUS_WRITE, 3'd6, 1'b0, 8'h00);
    send_command(CMD_BUS_WRITE, 3'd6, 1'b0, 8'h3C);
    send_command(CMD_LINE_TAKE, 3'd0, 1'b1, 8'h00);
    send_command(CMD_LINE_TAKE, 3'd0, 1'b1, 8'h00);
    send_command(CMD_BUS_WRITE, 3'd4, 1'b0, 8'h80);
    send_command(CMD_LINE_RX, 3'd0, 1'b1, 8'h00);
    send_command(CMD_BUS_WRITE, 3'd6, 1'b0, 8'h11);
    send_command(CMD_BUS_WRITE, 3'd4, 1'b0, 8'h83);
    send_command(CMD_LINE_TAKE, 3'd0, 1'b1, 8'h00);
    send_command(CMD_BUS_READ, 3'd6, 1'b0, 8'h00);
    send_command(CMD_BUS_READ, 3'd4, 1'b0, 8'h00);
    send_command(CMD_BUS_WRITE, 3'd0, 1'b0, 8'h03);
    send_command(CMD_BUS_READ, 3'd5, 1'b1, 8'h00);

    // Random traffic with idling on both sides.
    repeat (500) send_random();

    // A stretch with no idling at all.
    steady = 1'b1;
    repeat (200) send_random();
    steady = 1'b0;

    // The receiver holds off while words keep coming, so the block fills.
    hold_off_req = 1'b1;
    steady       = 1'b1;
    repeat (100) send_random();
    steady = 1'b0;

    repeat (330) send_random();
    in_ch.valid <= 1'b0;

    // Let the outstanding replies drain before the final check.
    drain = 0;
    while (sb.due_replies.size() > 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);

    if (sb.errors == 0 && sb.due_replies.size() == 0) begin
      $display("PASS");
    end else begin
      if (sb.due_replies.size() > 0)
        $display("%0t: %0d replies never arrived", $time, sb.due_replies.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
